FILE: design/deadline_timer_table_macros.svh
// Assertion macros for the deadline timer table checker.
// Depends on nothing; included by the checker file only.
`ifndef DEADLINE_TIMER_TABLE_MACROS_SVH
`define DEADLINE_TIMER_TABLE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DTT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DTT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/dtt_pkg.sv
// Shared types and constants for the deadline timer table.
// Used by the controller, the datapath, the top level and the checker.
package dtt_pkg;

	localparam int TIME_W          = 32;
	localparam int DELAY_W         = 31;
	localparam int TID_W           = 16;
	localparam int KIND_W          = 3;
	localparam int REQ_W           = 2;
	localparam int MAX_FIRE        = 16;
	localparam int FIRE_CNT_W      = $clog2(MAX_FIRE + 1);
	localparam int DEF_TIMER_SLOTS = 16;
	localparam int DEF_ID_BITS     = 16;

	// Request codes carried by req_type.
	typedef enum logic [REQ_W-1:0] {
		REQ_TICK   = 2'd0,
		REQ_SET    = 2'd1,
		REQ_CANCEL = 2'd2,
		REQ_NOP    = 2'd3
	} req_t;

	// Result codes carried by event_kind.
	typedef enum logic [KIND_W-1:0] {
		EV_SET_OK    = 3'd0,
		EV_SET_FULL  = 3'd1,
		EV_CANCELLED = 3'd2,
		EV_NOT_FOUND = 3'd3,
		EV_FIRED     = 3'd4
	} event_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic scan_start;
		logic issue;
		logic commit_set;
		logic commit_cancel;
		logic take_fire;
		logic emit_pend;
		logic pend_last;
	} dtt_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		req_t req;
		logic last_idx;
		logic out_free;
		logic hit_found;
		logic best_found;
		logic pend_valid;
		logic fire_last;
	} dtt_status_t;

endpackage

FILE: design/dtt_ctrl.sv
// Controller state machine for the deadline timer table.
// Depends on dtt_pkg for the command, status and request types.
module dtt_ctrl import dtt_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic [REQ_W-1:0]   req_type,
	output logic               in_stall,
	input  dtt_status_t        status,
	output dtt_cmd_t           cmd
);

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_SCAN   = 5'b00010,
		ST_DRAIN  = 5'b00100,
		ST_DECIDE = 5'b01000,
		ST_FLUSH  = 5'b10000
	} state_t;

	state_t state_q;
	state_t state_d;

	// Next state and commands.
	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		in_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load       = 1'b1;
					cmd.scan_start = 1'b1;
					if (req_t'(req_type) != REQ_NOP) begin
						state_d = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				cmd.issue = 1'b1;
				if (status.last_idx) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				unique case (status.req)
					REQ_SET: begin
						if (status.out_free) begin
							cmd.commit_set = 1'b1;
							state_d        = ST_IDLE;
						end
					end
					REQ_CANCEL: begin
						if (status.out_free) begin
							cmd.commit_cancel = 1'b1;
							state_d           = ST_IDLE;
						end
					end
					REQ_TICK: begin
						// A held fired result goes out once the next pass shows
						// whether another timer follows it.
						if (!status.pend_valid || status.out_free) begin
							cmd.emit_pend = status.pend_valid;
							if (status.best_found) begin
								cmd.take_fire = 1'b1;
								if (status.fire_last) begin
									state_d = ST_FLUSH;
								end else begin
									cmd.scan_start = 1'b1;
									state_d        = ST_SCAN;
								end
							end else begin
								cmd.pend_last = 1'b1;
								state_d       = ST_IDLE;
							end
						end
					end
					default: begin
						state_d = ST_IDLE;
					end
				endcase
			end
			ST_FLUSH: begin
				if (status.out_free) begin
					cmd.emit_pend = 1'b1;
					cmd.pend_last = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

FILE: design/dtt_datapath.sv
// Datapath of the deadline timer table: slot memory, scan pipeline,
// search registers, counters and the output register. Depends on dtt_pkg.
module dtt_datapath import dtt_pkg::*; #(
	parameter int TIMER_SLOTS = DEF_TIMER_SLOTS,
	parameter int ID_BITS     = DEF_ID_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [REQ_W-1:0]   req_type,
	input  logic [DELAY_W-1:0] delay_ms,
	input  logic [TID_W-1:0]   timer_id,
	input  dtt_cmd_t           cmd,
	output dtt_status_t        status,
	input  logic               out_stall,
	output logic               out_valid,
	output logic [KIND_W-1:0]  event_kind,
	output logic [TID_W-1:0]   timer_id_out,
	output logic               last
);

	localparam int IDX_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
	localparam int CMP_W = (ID_BITS > TID_W) ? ID_BITS : TID_W;

	// Latched transaction.
	req_t               req_q;
	logic [DELAY_W-1:0] delay_q;
	logic [TID_W-1:0]   want_q;

	// Timer state.
	logic [TIME_W-1:0]  now_q;
	logic [ID_BITS-1:0] next_id_q;
	logic               valid_q [TIMER_SLOTS];
	logic [TIME_W-1:0]  dl_mem [TIMER_SLOTS];
	logic [ID_BITS-1:0] id_mem [TIMER_SLOTS];

	// Scan pipeline.
	logic [IDX_W-1:0]   idx_q;
	logic               issue_s1;
	logic               rd_valid_s1;
	logic [TIME_W-1:0]  rd_dl_s1;
	logic [ID_BITS-1:0] rd_id_s1;
	logic [IDX_W-1:0]   rd_idx_s1;

	// Search results.
	logic               hit_found_q;
	logic [IDX_W-1:0]   hit_idx_q;
	logic               best_found_q;
	logic [TIME_W-1:0]  best_age_q;
	logic [ID_BITS-1:0] best_id_q;
	logic [IDX_W-1:0]   best_idx_q;

	// Fired result held until the next pass decides its last flag.
	logic                  pend_valid_q;
	logic [ID_BITS-1:0]    pend_id_q;
	logic [FIRE_CNT_W-1:0] fire_cnt_q;

	// Output register.
	logic             out_valid_q;
	event_t           out_kind_q;
	logic [TID_W-1:0] out_id_q;
	logic             out_last_q;

	logic              out_free;
	logic              emit_any;
	logic [TIME_W-1:0] diff_s1;
	logic [TIME_W-1:0] age_s1;
	logic              expired_s1;
	logic              better_s1;
	logic              cand_fire;
	logic              free_hit;
	logic              cancel_hit;

	// Latch the request fields when a transaction is accepted.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q   <= req_t'(req_type);
			delay_q <= delay_ms;
			want_q  <= timer_id;
		end
	end

	// Millisecond counter and id counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q     <= '0;
			next_id_q <= '0;
		end else begin
			if (cmd.load && req_t'(req_type) == REQ_TICK) begin
				now_q <= now_q + 1'b1;
			end
			if (cmd.commit_set && hit_found_q) begin
				next_id_q <= next_id_q + 1'b1;
			end
		end
	end

	// Slot valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '{default: 1'b0};
		end else begin
			if (cmd.commit_set && hit_found_q) begin
				valid_q[hit_idx_q] <= 1'b1;
			end
			if (cmd.commit_cancel && hit_found_q) begin
				valid_q[hit_idx_q] <= 1'b0;
			end
			if (cmd.take_fire) begin
				valid_q[best_idx_q] <= 1'b0;
			end
		end
	end

	// Slot memory: one write port, one registered read port for the scan.
	always_ff @(posedge clk) begin
		if (cmd.commit_set && hit_found_q) begin
			dl_mem[hit_idx_q] <= now_q + TIME_W'(delay_q);
			id_mem[hit_idx_q] <= next_id_q;
		end
		if (cmd.issue) begin
			rd_dl_s1    <= dl_mem[idx_q];
			rd_id_s1    <= id_mem[idx_q];
			rd_valid_s1 <= valid_q[idx_q];
			rd_idx_s1   <= idx_q;
		end
	end

	// Scan index and stage flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q    <= '0;
			issue_s1 <= 1'b0;
		end else begin
			issue_s1 <= cmd.issue;
			if (cmd.scan_start) begin
				idx_q <= '0;
			end else if (cmd.issue) begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	// Evaluate the slot read in the previous cycle.
	always_comb begin
		diff_s1    = rd_dl_s1 - now_q;
		age_s1     = now_q - rd_dl_s1;
		expired_s1 = (diff_s1 == '0) || diff_s1[TIME_W-1];
		better_s1  = !best_found_q || (age_s1 > best_age_q) ||
			((age_s1 == best_age_q) && (rd_id_s1 < best_id_q));
		cand_fire  = issue_s1 && (req_q == REQ_TICK) && rd_valid_s1 && expired_s1;
		free_hit   = issue_s1 && (req_q == REQ_SET) && !rd_valid_s1 && !hit_found_q;
		cancel_hit = issue_s1 && (req_q == REQ_CANCEL) && rd_valid_s1 && !hit_found_q &&
			(CMP_W'(rd_id_s1) == CMP_W'(want_q));
	end

	// Search flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_found_q  <= 1'b0;
			best_found_q <= 1'b0;
		end else if (cmd.scan_start) begin
			hit_found_q  <= 1'b0;
			best_found_q <= 1'b0;
		end else begin
			if (free_hit || cancel_hit) begin
				hit_found_q <= 1'b1;
			end
			if (cand_fire && better_s1) begin
				best_found_q <= 1'b1;
			end
		end
	end

	// Search payload: first free or matching slot, oldest expired slot.
	always_ff @(posedge clk) begin
		if (free_hit || cancel_hit) begin
			hit_idx_q <= rd_idx_s1;
		end
		if (cand_fire && better_s1) begin
			best_age_q <= age_s1;
			best_id_q  <= rd_id_s1;
			best_idx_q <= rd_idx_s1;
		end
		if (cmd.take_fire) begin
			pend_id_q <= best_id_q;
		end
	end

	// Pending fired result and fire count for the current tick.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			fire_cnt_q   <= '0;
		end else if (cmd.load) begin
			pend_valid_q <= 1'b0;
			fire_cnt_q   <= '0;
		end else begin
			if (cmd.take_fire) begin
				pend_valid_q <= 1'b1;
				fire_cnt_q   <= fire_cnt_q + 1'b1;
			end else if (cmd.emit_pend) begin
				pend_valid_q <= 1'b0;
			end
		end
	end

	// Output register: free when empty or taken in this cycle.
	assign out_free = !out_valid_q || !out_stall;
	assign emit_any = cmd.commit_set || cmd.commit_cancel || cmd.emit_pend;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_any) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit_set) begin
			out_kind_q <= hit_found_q ? EV_SET_OK : EV_SET_FULL;
			out_id_q   <= hit_found_q ? TID_W'(next_id_q) : '0;
			out_last_q <= 1'b1;
		end else if (cmd.commit_cancel) begin
			out_kind_q <= hit_found_q ? EV_CANCELLED : EV_NOT_FOUND;
			out_id_q   <= want_q;
			out_last_q <= 1'b1;
		end else if (cmd.emit_pend) begin
			out_kind_q <= EV_FIRED;
			out_id_q   <= TID_W'(pend_id_q);
			out_last_q <= cmd.pend_last;
		end
	end

	assign out_valid    = out_valid_q;
	assign event_kind   = out_kind_q;
	assign timer_id_out = out_id_q;
	assign last         = out_last_q;

	// Status to the controller.
	always_comb begin
		status.req        = req_q;
		status.last_idx   = (idx_q == IDX_W'(TIMER_SLOTS - 1));
		status.out_free   = out_free;
		status.hit_found  = hit_found_q;
		status.best_found = best_found_q;
		status.pend_valid = pend_valid_q;
		status.fire_last  = (fire_cnt_q == FIRE_CNT_W'(MAX_FIRE - 1));
	end

endmodule

FILE: design/deadline_timer_table.sv
// Sequencing: a set or cancel loads its result after one scan pass over all slots; a tick that
// fires k timers ends after (k + 1) passes, or 16 passes and the flush state when k is sixteen.
// Throughput: one transaction at a time; a pass reads one slot per cycle through the single
// read port, and a stalled output register holds the decision.
// Reset: arst_n clears the valid bits, time and id counters, controller and output valid;
// deadlines and ids in the slot memory are not cleared and are read only from valid slots.
module deadline_timer_table import dtt_pkg::*; #(
	parameter int TIMER_SLOTS = DEF_TIMER_SLOTS,
	parameter int ID_BITS     = DEF_ID_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [REQ_W-1:0]   req_type,
	input  logic [DELAY_W-1:0] delay_ms,
	input  logic [TID_W-1:0]   timer_id,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [KIND_W-1:0]  event_kind,
	output logic [TID_W-1:0]   timer_id_out,
	output logic               last
);

	dtt_cmd_t    cmd;
	dtt_status_t status;

	// Sequencing of scans, decisions and result hand-off.
	dtt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.req_type (req_type),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	// Slot table, counters and output register.
	dtt_datapath #(
		.TIMER_SLOTS (TIMER_SLOTS),
		.ID_BITS     (ID_BITS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_type     (req_type),
		.delay_ms     (delay_ms),
		.timer_id     (timer_id),
		.cmd          (cmd),
		.status       (status),
		.out_stall    (out_stall),
		.out_valid    (out_valid),
		.event_kind   (event_kind),
		.timer_id_out (timer_id_out),
		.last         (last)
	);

endmodule

FILE: design/dtt_checker.sv
// Port-level checker for the deadline timer table, bound to the top level.
// Depends on dtt_pkg and deadline_timer_table_macros.svh.
`include "deadline_timer_table_macros.svh"

module dtt_checker import dtt_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic [REQ_W-1:0]   req_type,
	input logic               out_valid,
	input logic               out_stall,
	input logic [KIND_W-1:0]  event_kind,
	input logic [TID_W-1:0]   timer_id_out,
	input logic               last
);

	// A stalled result transaction holds its payload.
	`DTT_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(event_kind) && $stable(timer_id_out) && $stable(last), "stalled result changed")

	// Set and cancel give exactly one result, so it always closes the transaction.
	`DTT_ASSERT_NOW(a_single_last, clk, arst_n, out_valid && (event_kind != EV_FIRED), last, "set or cancel result without last")

	// A rejected set reports id zero.
	`DTT_ASSERT_NOW(a_full_id, clk, arst_n, out_valid && (event_kind == EV_SET_FULL), timer_id_out == '0, "full result with nonzero id")

	// After taking a real request the block is busy scanning.
	`DTT_ASSERT_NEXT(a_busy, clk, arst_n, in_valid && !in_stall && (req_type != REQ_NOP), in_stall, "request accepted while scan pending")

endmodule

bind deadline_timer_table dtt_checker u_dtt_checker (.*);
